// File: rtl/l4cs_pkg.sv
// Shared types and constants for the IPv4 / TCP / UDP checksum engine.
// Used by the front, queue, back and top-level modules; depends on nothing.
`timescale 1ns / 1ps

package l4cs_pkg;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_VER   = 3'd1;
	localparam logic [2:0] ST_TOO_LONG  = 3'd2;
	localparam logic [2:0] ST_TOO_SHORT = 3'd3;
	localparam logic [2:0] ST_BAD_UDP   = 3'd4;
	localparam logic [2:0] ST_TRUNC     = 3'd5;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_TCP  = 2'd1;
	localparam logic [1:0] KIND_UDP  = 2'd2;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam logic [7:0] VER_IHL   = 8'h45;

	// One finished packet, handed from the byte front end to the back end.
	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  kind;
		logic [19:0] hdr_sum;
		logic [31:0] l4_sum;
		logic [15:0] l4_len;
	} l4cs_rec_t;

endpackage

// File: rtl/l4cs_front.sv
// Byte front end: parses the IPv4 header, checks lengths and accumulates the sums.
// Depends on l4cs_pkg; emits one l4cs_rec_t per packet on its final byte.
`timescale 1ns / 1ps

module l4cs_front
	import l4cs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tlast,
	input  logic        q_full,
	output logic        push,
	output l4cs_rec_t   push_rec
);

	logic [15:0] max_len_q;
	logic [15:0] pos_q;
	logic [19:0] hsum_q;
	logic [31:0] tsum_q;
	logic [15:0] tlen_q;
	logic [7:0]  proto_q;
	logic [15:0] ulen_q;
	logic [7:0]  hold_q;
	logic [2:0]  err_q;

	logic [15:0] pos_n, tlen_n, ulen_n, p, word;
	logic [19:0] hsum_n;
	logic [31:0] tsum_n;
	logic [7:0]  proto_n, b;
	logic [2:0]  err_n, status;
	logic        l4_counts, accept;

	assign s_axis_tready = !q_full;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign push = accept && s_axis_tlast;

	always_comb begin
		b = s_axis_tdata;
		p = pos_q;
		word = p[0] ? {8'd0, b} : {b, 8'd0};
		pos_n = (pos_q != 16'hffff) ? pos_q + 16'd1 : pos_q;
		err_n = err_q;
		tlen_n = tlen_q;
		proto_n = proto_q;
		ulen_n = ulen_q;
		hsum_n = hsum_q;
		tsum_n = tsum_q;

		// Header field capture and checks; the first error found is kept.
		if (err_q == ST_OK) begin
			if (p == 16'd0 && b != VER_IHL)
				err_n = ST_BAD_VER;
			if (p == 16'd3) begin
				tlen_n = {hold_q, b};
				if (tlen_n > max_len_q)
					err_n = ST_TOO_LONG;
				else if (tlen_n < 16'd20)
					err_n = ST_TOO_SHORT;
			end
			if (p == 16'd9)
				proto_n = b;
			if (p == 16'd25 && proto_q == PROTO_UDP) begin
				ulen_n = {hold_q, b};
				if (ulen_n < 16'd8 || ({1'b0, ulen_n} + 17'd20) > {1'b0, tlen_q})
					err_n = ST_BAD_UDP;
			end
		end

		// Does this byte belong to the transport checksum?
		l4_counts = 1'b0;
		if (p >= 16'd20 && p < tlen_n) begin
			if (proto_n == PROTO_TCP)
				l4_counts = (p != 16'd36) && (p != 16'd37);
			else if (proto_n == PROTO_UDP)
				l4_counts = (p != 16'd26) && (p != 16'd27) &&
					(p < 16'd26 || {1'b0, p} < ({1'b0, ulen_n} + 17'd20));
		end

		if (err_n == ST_OK) begin
			if (p < 16'd20) begin
				if (p != 16'd10 && p != 16'd11)
					hsum_n = hsum_q + {4'd0, word};
				if (p >= 16'd12)
					tsum_n = tsum_q + {16'd0, word};
			end else if (l4_counts) begin
				tsum_n = tsum_q + {16'd0, word};
			end
		end

		// Final status as seen on the last byte.
		status = err_n;
		if (status == ST_OK && (pos_n < 16'd4 || pos_n < tlen_n))
			status = ST_TRUNC;
		if (status == ST_OK && proto_n == PROTO_UDP && pos_n < 16'd26)
			status = ST_BAD_UDP;

		push_rec.status = status;
		push_rec.hdr_sum = hsum_n;
		push_rec.l4_sum = tsum_n;
		if (status != ST_OK)
			push_rec.kind = KIND_NONE;
		else if (proto_n == PROTO_TCP)
			push_rec.kind = KIND_TCP;
		else if (proto_n == PROTO_UDP)
			push_rec.kind = KIND_UDP;
		else
			push_rec.kind = KIND_NONE;
		push_rec.l4_len = (proto_n == PROTO_TCP) ? tlen_n - 16'd20 : ulen_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= 16'hffff;
			pos_q <= '0;
			hsum_q <= '0;
			tsum_q <= '0;
			tlen_q <= '0;
			proto_q <= '0;
			ulen_q <= '0;
			hold_q <= '0;
			err_q <= ST_OK;
		end else begin
			if (cfg_valid)
				max_len_q <= cfg_data;
			if (accept) begin
				if (s_axis_tlast) begin
					pos_q <= '0;
					hsum_q <= '0;
					tsum_q <= '0;
					tlen_q <= '0;
					proto_q <= '0;
					ulen_q <= '0;
					hold_q <= '0;
					err_q <= ST_OK;
				end else begin
					pos_q <= pos_n;
					hsum_q <= hsum_n;
					tsum_q <= tsum_n;
					tlen_q <= tlen_n;
					proto_q <= proto_n;
					ulen_q <= ulen_n;
					hold_q <= s_axis_tdata;
					err_q <= err_n;
				end
			end
		end
	end

endmodule

// File: rtl/l4cs_queue.sv
// Small first-in first-out queue of per-packet records between front and back.
// Depends on l4cs_pkg for the record type.
`timescale 1ns / 1ps

module l4cs_queue
	import l4cs_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  l4cs_rec_t push_rec,
	output logic      full,
	input  logic      pop,
	output logic      empty,
	output l4cs_rec_t pop_rec
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	l4cs_rec_t    mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign pop_rec = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push && !full)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop && !empty)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/l4cs_back.sv
// Back end: adds the pseudo-header terms, folds both sums and holds the result.
// Depends on l4cs_pkg; reads records from l4cs_queue.
`timescale 1ns / 1ps

module l4cs_back
	import l4cs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  l4cs_rec_t   q_rec,
	output logic        q_pop,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser
);

	// Ones-complement fold of a 32-bit sum down to 16 bits, then inverted.
	function automatic logic [15:0] fold_cpl(input logic [31:0] s);
		logic [16:0] t;
		logic [15:0] u;
		t = {1'b0, s[31:16]} + {1'b0, s[15:0]};
		u = t[15:0] + {15'd0, t[16]};
		return ~u;
	endfunction

	logic        adv;
	logic        valid_s1;
	logic [2:0]  status_s1;
	logic [1:0]  kind_s1;
	logic [19:0] hsum_s1;
	logic [31:0] lsum_s1;
	logic [31:0] lsum_n;

	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [15:0] ipc_q, l4c_q;
	logic [1:0]  kind_q;

	assign adv = !out_valid_q || m_axis_tready;
	assign q_pop = adv && !q_empty;

	always_comb begin
		lsum_n = q_rec.l4_sum + {16'd0, q_rec.l4_len} +
			((q_rec.kind == KIND_TCP) ? {24'd0, PROTO_TCP} : {24'd0, PROTO_UDP});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s1 <= q_rec.status;
			kind_s1 <= q_rec.kind;
			hsum_s1 <= q_rec.hdr_sum;
			lsum_s1 <= lsum_n;
			status_q <= status_s1;
			kind_q <= kind_s1;
			ipc_q <= (status_s1 == ST_OK) ? fold_cpl({12'd0, hsum_s1}) : 16'd0;
			l4c_q <= (kind_s1 != KIND_NONE) ? fold_cpl(lsum_s1) : 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1 <= !q_empty;
			out_valid_q <= valid_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {5'd0, l4c_q, ipc_q, status_q};
	assign m_axis_tuser = kind_q;

endmodule

// File: rtl/ipv4_l4_checksum_engine.sv
// IPv4 header and TCP/UDP checksum engine: top level wiring front, queue and back.
// Depends on l4cs_pkg, l4cs_front, l4cs_queue and l4cs_back.
`timescale 1ns / 1ps

// The engine takes an IPv4 packet one byte per item on the input stream, in
// network order, starting with the first header byte, and tlast set on the
// final byte. For every packet it returns exactly one result item, issued for
// that final byte: a status code, the header checksum (with the header check
// field taken as zero) and, for TCP or UDP, the transport checksum including
// the pseudo-header. Only version 4 with a 20-byte header is accepted. The
// total length is checked against the max_total_length register (written on
// the cfg channel, reset value 65535) and against the 20-byte minimum, and the
// UDP length is checked against the total length minus 20. A packet that ends
// before its total length is reported as truncated; bytes past the total
// length are ignored. The checksums are reported, the packet itself is not
// modified. The byte front end does its adds and its position logic per
// byte, so a new item is accepted in every cycle unless the record queue is
// full. The result of a packet passes in order through the record queue,
// the pseudo-header add and the fold into the output register. The input
// stalls only when the record queue holds QUEUE_DEPTH finished packets that
// the output side has not yet taken, which only happens under output
// backpressure.
module ipv4_l4_checksum_engine
	import l4cs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: max_total_length.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	// Input stream; tdata is data_byte, tlast is last_byte.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tlast,
	// Result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [2:0] status, [18:3] ip_checksum,
	                                   // [34:19] l4_checksum, [39:35] zero
	output logic [1:0]  m_axis_tuser   // [1:0] l4_kind
);

	logic      q_full, q_empty, q_push, q_pop;
	l4cs_rec_t push_rec, pop_rec;

	// The register lives in the front end and may be written in any cycle.
	assign cfg_ready = 1'b1;

	l4cs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (q_full),
		.push          (q_push),
		.push_rec      (push_rec)
	);

	// Finished-packet records wait here so either side can stall alone.
	l4cs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (push_rec),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.pop_rec  (pop_rec)
	);

	l4cs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_rec         (pop_rec),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// File: dv/ipv4_l4_checksum_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for ipv4_l4_checksum_engine: IPv4 packets go in one byte per item,
// and every result item is compared with a checksum predictor that runs inside this file.
// Depends only on l4cs_pkg and the ipv4_l4_checksum_engine RTL.

module ipv4_l4_checksum_engine_tb;
	import l4cs_pkg::*;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] ip_cs;
		logic [15:0] l4_cs;
		logic [1:0]  kind;
	} cs_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;        // [2:0] status, [18:3] ip_checksum, [34:19] l4_checksum
	logic [1:0]  m_axis_tuser;        // [1:0] l4_kind

	ipv4_l4_checksum_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#8_000_000;
		$display("ipv4_l4_checksum_engine verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Checksum predictor: its own copy of the packet state and register.
	// ------------------------------------------------------------------
	logic [15:0] max_len_reg;
	logic [15:0] rx_count;
	logic [19:0] hdr_acc;
	logic [31:0] l4_acc;
	logic [15:0] tot_len;
	logic [7:0]  proto;
	logic [15:0] udp_len;
	logic [7:0]  prev_byte;
	logic [2:0]  err_code;
	cs_result_t  pending_results[$];
	int          fail_count = 0;

	function automatic void clear_packet_state();
		rx_count  = '0;
		hdr_acc   = '0;
		l4_acc    = '0;
		tot_len   = '0;
		proto     = '0;
		udp_len   = '0;
		prev_byte = '0;
		err_code  = ST_OK;
	endfunction

	// End-around-carry fold followed by the one's complement.
	function automatic logic [15:0] fold_sum(input logic [31:0] s);
		logic [31:0] t;
		t = (s >> 16) + (s & 32'h0000_ffff);
		t = t + (t >> 16);
		return ~t[15:0];
	endfunction

	// True when a byte past the IP header belongs to the transport checksum.
	function automatic bit l4_byte_summed(input int unsigned p);
		if (p < 20 || p >= tot_len)
			return 0;
		if (proto == PROTO_TCP)
			return p != 36 && p != 37;
		if (proto == PROTO_UDP) begin
			if (p == 26 || p == 27)
				return 0;
			return p < 26 || p < 20 + udp_len;
		end
		return 0;
	endfunction

	function automatic void predict_byte(input logic [7:0] b, input logic last);
		int unsigned p;
		int unsigned received;
		logic [31:0] word;
		cs_result_t r;
		p = {16'd0, rx_count};
		word = (p % 2 == 0) ? {16'd0, b, 8'd0} : {24'd0, b};
		if (rx_count != 16'hffff)
			rx_count = rx_count + 16'd1;

		// Field checks; the first error found in a packet is kept.
		if (err_code == ST_OK) begin
			if (p == 0 && b != VER_IHL)
				err_code = ST_BAD_VER;
			if (p == 3) begin
				tot_len = {prev_byte, b};
				if (tot_len > max_len_reg)
					err_code = ST_TOO_LONG;
				else if (tot_len < 20)
					err_code = ST_TOO_SHORT;
			end
			if (p == 9)
				proto = b;
			if (p == 25 && proto == PROTO_UDP) begin
				udp_len = {prev_byte, b};
				if (udp_len < 8 || udp_len + 32'd20 > tot_len)
					err_code = ST_BAD_UDP;
			end
		end

		// Addresses (bytes 12..19) feed both sums; the header check field feeds neither.
		if (err_code == ST_OK) begin
			if (p < 20) begin
				if (p != 10 && p != 11)
					hdr_acc = hdr_acc + word[19:0];
				if (p >= 12)
					l4_acc = l4_acc + word;
			end else if (l4_byte_summed(p)) begin
				l4_acc = l4_acc + word;
			end
		end
		prev_byte = b;
		if (!last)
			return;

		received = {16'd0, rx_count};
		r = '0;
		r.status = err_code;
		if (r.status == ST_OK && (received < 4 || received < tot_len))
			r.status = ST_TRUNC;
		if (r.status == ST_OK && proto == PROTO_UDP && received < 26)
			r.status = ST_BAD_UDP;
		if (r.status == ST_OK) begin
			r.ip_cs = fold_sum({12'd0, hdr_acc});
			if (proto == PROTO_TCP) begin
				r.kind  = KIND_TCP;
				r.l4_cs = fold_sum(l4_acc + PROTO_TCP + (tot_len - 32'd20));
			end else if (proto == PROTO_UDP) begin
				r.kind  = KIND_UDP;
				r.l4_cs = fold_sum(l4_acc + PROTO_UDP + udp_len);
			end
		end
		pending_results.push_back(r);
		clear_packet_state();
	endfunction

	// ------------------------------------------------------------------
	// Result side: checks each accepted item and drives its own stall pattern.
	// ------------------------------------------------------------------
	int stall_mode = 0;
	int stall_left = 0;
	int cyc = 0;

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : result_monitor
		cs_result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result item with none expected: tdata 0x%0h, tuser %0d",
					m_axis_tdata, m_axis_tuser);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", {13'd0, want.status}, {13'd0, m_axis_tdata[2:0]});
				check_field("ip_checksum", want.ip_cs, m_axis_tdata[18:3]);
				check_field("l4_checksum", want.l4_cs, m_axis_tdata[34:19]);
				check_field("l4_kind", {14'd0, want.kind}, {14'd0, m_axis_tuser});
			end
		end

		// Stall pattern: modes held for random stretches, one of them never stalling.
		cyc++;
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 200);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= (cyc % 3) != 0;
			2: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= (cyc % 16) == 0;
		endcase
	end

	// ------------------------------------------------------------------
	// Input side.
	// ------------------------------------------------------------------
	int         burst_left = 1;
	bit         steady_send = 0;   // no gaps at all while set
	bit         valid_held = 0;
	int         bytes_sent = 0;
	logic [7:0] pkt_buf[$];

	// Offers one byte, waits for it to be taken, then maybe opens a gap.
	task automatic send_byte(input logic [7:0] b, input logic last);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		valid_held = 1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_byte(b, last);
		bytes_sent++;
		if (!steady_send) begin
			burst_left--;
			if (burst_left <= 0) begin
				s_axis_tvalid <= 1'b0;
				valid_held = 0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end
		end
	endtask

	// Stops sending and waits until every expected result has come out.
	task automatic drain();
		if (valid_held) begin
			s_axis_tvalid <= 1'b0;
			valid_held = 0;
		end
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_max_len(input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		max_len_reg = v;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Fills pkt_buf with wire_len bytes; every byte not named here is random.
	task automatic build_packet(input logic [7:0] ver_ihl, input logic [15:0] total,
			input logic [7:0] protocol, input logic [15:0] udp_field, input int wire_len);
		int i;
		logic [7:0] b;
		pkt_buf.delete();
		for (i = 0; i < wire_len; i++) begin
			b = 8'($urandom_range(0, 255));
			case (i)
				0: b = ver_ihl;
				2: b = total[15:8];
				3: b = total[7:0];
				9: b = protocol;
				24: if (protocol == PROTO_UDP) b = udp_field[15:8];
				25: if (protocol == PROTO_UDP) b = udp_field[7:0];
				default: ;
			endcase
			pkt_buf.push_back(b);
		end
	endtask

	task automatic send_packet();
		int i;
		for (i = 0; i < pkt_buf.size(); i++)
			send_byte(pkt_buf[i], i == pkt_buf.size() - 1);
	endtask

	task automatic put(input logic [7:0] ver_ihl, input logic [15:0] total,
			input logic [7:0] protocol, input logic [15:0] udp_field, input int wire_len);
		build_packet(ver_ihl, total, protocol, udp_field, wire_len);
		send_packet();
	endtask

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------
	task automatic test_good_packets();
		write_max_len(16'hffff);
		put(VER_IHL, 16'd20, 8'd1, 16'd0, 20);         // header only
		put(VER_IHL, 16'd33, 8'd47, 16'd0, 33);        // other protocol, no L4 sum
		put(VER_IHL, 16'd40, PROTO_TCP, 16'd0, 40);
		put(VER_IHL, 16'd41, PROTO_TCP, 16'd0, 41);    // odd byte padded
		put(VER_IHL, 16'd28, PROTO_UDP, 16'd8, 28);    // smallest UDP
		put(VER_IHL, 16'd33, PROTO_UDP, 16'd13, 33);   // odd UDP length
		put(VER_IHL, 16'd40, PROTO_UDP, 16'd12, 40);   // UDP shorter than IP payload
	endtask

	task automatic test_header_errors();
		put(8'h46, 16'd20, 8'd1, 16'd0, 20);           // wrong IHL
		put(8'h55, 16'd20, 8'd1, 16'd0, 20);           // wrong version
		put(8'hff, 16'd20, PROTO_TCP, 16'd0, 20);
		put(VER_IHL, 16'd19, 8'd1, 16'd0, 20);         // below minimum length
		put(VER_IHL, 16'd0, PROTO_TCP, 16'd0, 20);
		put(8'h00, 16'd0, 8'd1, 16'd0, 20);            // version error beats length error
	endtask

	task automatic test_early_end();
		put(VER_IHL, 16'd20, 8'd1, 16'd0, 1);          // ends on the first byte
		put(8'h00, 16'd20, 8'd1, 16'd0, 1);
		put(VER_IHL, 16'd20, 8'd1, 16'd0, 3);          // ends before the length is known
		put(VER_IHL, 16'd60, PROTO_TCP, 16'd0, 45);
		put(VER_IHL, 16'd30, 8'd2, 16'd0, 36);         // link padding after the packet
		put(VER_IHL, 16'd24, PROTO_UDP, 16'd0, 24);    // no room for the UDP length
		put(VER_IHL, 16'd25, PROTO_UDP, 16'd5, 26);
		put(VER_IHL, 16'd40, PROTO_UDP, 16'd7, 40);    // UDP length under 8
		put(VER_IHL, 16'd40, PROTO_UDP, 16'd21, 40);   // UDP length over the payload
		put(VER_IHL, 16'd40, PROTO_UDP, 16'd20, 45);   // exact UDP length plus padding
		put(VER_IHL, 16'd40, PROTO_UDP, 16'd20, 25);   // cut off before the UDP length
	endtask

	task automatic test_length_limit();
		drain();
		write_max_len(16'd20);
		put(VER_IHL, 16'd20, 8'd1, 16'd0, 20);
		put(VER_IHL, 16'd21, 8'd1, 16'd0, 21);
		put(VER_IHL, 16'd40, PROTO_TCP, 16'd0, 40);
		put(8'h44, 16'd40, PROTO_TCP, 16'd0, 40);
		drain();
		write_max_len(16'hffff);
	endtask

	task automatic random_packet();
		int sel;
		int total;
		int wire_len;
		logic [7:0] protocol;
		logic [7:0] ver;
		logic [15:0] udp_field;
		sel = $urandom_range(0, 9);
		case ($urandom_range(0, 3))
			0: protocol = PROTO_TCP;
			1: protocol = PROTO_UDP;
			2: protocol = 8'($urandom_range(0, 255));
			default: protocol = PROTO_UDP;
		endcase
		total = (protocol == PROTO_UDP) ? $urandom_range(28, 80) : $urandom_range(20, 80);
		udp_field = 16'($urandom_range(8, total - 20));
		ver = VER_IHL;
		wire_len = total + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
		if (sel == 7) begin
			ver = 8'($urandom_range(0, 255));
		end else if (sel == 8) begin
			wire_len = $urandom_range(1, total);
		end else if (sel == 9) begin
			total = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 65535) : $urandom_range(0, 90);
			udp_field = 16'($urandom_range(0, 65535));
			wire_len = $urandom_range(1, 90);
		end
		put(ver, 16'(total), protocol, udp_field, wire_len);
	endtask

	task automatic test_random_traffic();
		int phase;
		int start_bytes;
		for (phase = 0; phase < 4; phase++) begin
			drain();
			case (phase)
				0: write_max_len(16'hffff);
				1: write_max_len(16'($urandom_range(40, 80)));
				2: write_max_len(16'($urandom_range(20, 65535)));
				default: write_max_len(16'hffff);
			endcase
			steady_send = (phase == 1);
			start_bytes = bytes_sent;
			while (bytes_sent - start_bytes < 20)
				random_packet();
		end
		steady_send = 0;
	endtask

	initial begin
		clear_packet_state();
		max_len_reg = 16'hffff;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_good_packets();
		test_header_errors();
		test_early_end();
		test_length_limit();
		test_random_traffic();
		drain();

		if (fail_count == 0)
			$display("ipv4_l4_checksum_engine verification clean");
		else
			$display("ipv4_l4_checksum_engine verification failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/l4cs_pkg.sv
rtl/l4cs_front.sv
rtl/l4cs_queue.sv
rtl/l4cs_back.sv
rtl/ipv4_l4_checksum_engine.sv
dv/ipv4_l4_checksum_engine_tb.sv
